@@ sv/swlfg_pkg.sv @@
// Package for the sine-wave LED frame generator.
// Holds sizes, fixed-point constants, command and state codes, and the
// constant tables built at elaboration. No dependencies.
`default_nettype none

package swlfg_pkg;

  // Sizes
  localparam int unsigned LED_COUNT       = 64;
  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned QBITS           = SINE_TABLE_BITS - 2;
  localparam int unsigned QTAB_N          = (1 << QBITS) + 1;
  localparam int unsigned QTAB_IDX_W      = QBITS + 1;
  localparam int unsigned LED_IDX_W       = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned LED_INDEX_W     = 6;
  localparam int unsigned PHASE_W         = 38;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 16;

  // Division of the elapsed time by 1000, one byte digit at a time
  localparam int unsigned DIV_DIGITS = 5;
  localparam int unsigned DIG_W      = 3;
  localparam logic [18:0] DIV_M      = 19'd268436;  // ceil(2^28 / 1000)
  localparam logic [17:0] DIV_D      = 18'd1000;

  localparam logic [37:0] PHASE_LIMIT = 38'd10000 << 24;
  localparam logic [37:0] SCRUB_SCALE = 38'd2560;
  localparam logic [63:0] TURNS24     = 64'd16405566614;
  localparam logic [25:0] KMOT        = 26'd34178264;

  localparam logic [15:0] SPEED_RST     = 16'd5120;
  localparam logic [15:0] INTENSITY_RST = 16'd43520;

  localparam logic [63:0] SC1 = 64'd1686629713;
  localparam logic [63:0] SC3 = 64'd693598668;
  localparam logic [63:0] SC5 = 64'd85569306;
  localparam logic [63:0] SC7 = 64'd5026995;
  localparam logic [63:0] SC9 = 64'd172272;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED     = 1'b0,
    REG_INTENSITY = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_MUL,
    OP_DIV_REM,
    OP_PH_UPD,
    OP_PROD,
    OP_PROD_SUM,
    OP_MOT_MUL,
    OP_MOT_SUM,
    OP_PIXEL
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_MUL,
    ST_DIV_REM,
    ST_PH_UPD,
    ST_PROD,
    ST_PROD_SUM,
    ST_MOT_MUL,
    ST_MOT_SUM,
    ST_PIXEL
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e               op;
    logic [LED_IDX_W-1:0] led;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_adv;
  } dp_status_t;

  typedef logic [QTAB_N-1:0][15:0]    qtab_t;
  typedef logic [LED_COUNT-1:0][31:0] led_turn_t;
  typedef logic [255:0][7:0]          green_lut_t;

  // Quarter-wave sine in Q15 for in-quadrant positions 0 .. 2^QBITS
  function automatic qtab_t build_qtab();
    qtab_t       tab;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] t;
    logic [63:0] s;
    for (int p = 0; p < QTAB_N; p++) begin
      z  = 64'(p) << (16 - QBITS);
      z2 = (z * z) >> 16;
      t  = SC9;
      t  = SC7 - ((t * z2) >> 16);
      t  = SC5 - ((t * z2) >> 16);
      t  = SC3 - ((t * z2) >> 16);
      t  = SC1 - ((t * z2) >> 16);
      s  = ((t * z) >> 16) >> 15;
      if (s > 64'd32768) begin
        s = 64'd32768;
      end
      tab[p] = 16'(s);
    end
    return tab;
  endfunction

  // Spatial offset of each LED, in turns Q0.32
  function automatic led_turn_t build_led_turn();
    led_turn_t tab;
    for (int i = 0; i < LED_COUNT; i++) begin
      tab[i] = 32'((64'(i) * TURNS24) / (LED_COUNT - 1));
    end
    return tab;
  endfunction

  function automatic green_lut_t build_green_lut();
    green_lut_t tab;
    for (int v = 0; v < 256; v++) begin
      tab[v] = 8'((v * 62) / 100);
    end
    return tab;
  endfunction

  localparam qtab_t      QTAB      = build_qtab();
  localparam led_turn_t  LED_TURN  = build_led_turn();
  localparam green_lut_t GREEN_LUT = build_green_lut();

endpackage

`default_nettype wire

@@ sv/swlfg_ctrl.sv @@
// Sequencer for the frame generator: walks the division, phase update, motion term
// and pixel issue steps. Depends on swlfg_pkg.
`default_nettype none

module swlfg_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  output swlfg_pkg::dp_cmd_t         cmd_o,
  input  wire swlfg_pkg::dp_status_t status_i
);

  swlfg_pkg::ctrl_state_e                state_q, state_d;
  logic [swlfg_pkg::DIG_W-1:0]           dig_q, dig_d;
  logic [swlfg_pkg::LED_IDX_W-1:0]       led_q, led_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swlfg_pkg::ST_IDLE;
      dig_q   <= '0;
      led_q   <= '0;
    end else begin
      state_q <= state_d;
      dig_q   <= dig_d;
      led_q   <= led_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    dig_d      = dig_q;
    led_d      = led_q;
    in_ready_o = 1'b0;
    cmd_o.op   = swlfg_pkg::OP_NONE;
    cmd_o.led  = led_q;
    unique case (state_q)
      swlfg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = swlfg_pkg::OP_LOAD;
          dig_d    = '0;
          state_d  = swlfg_pkg::ST_DIV_MUL;
        end
      end
      swlfg_pkg::ST_DIV_MUL: begin
        cmd_o.op = swlfg_pkg::OP_DIV_MUL;
        state_d  = swlfg_pkg::ST_DIV_REM;
      end
      swlfg_pkg::ST_DIV_REM: begin
        cmd_o.op = swlfg_pkg::OP_DIV_REM;
        if (dig_q == swlfg_pkg::DIG_W'(swlfg_pkg::DIV_DIGITS - 1)) begin
          state_d = swlfg_pkg::ST_PH_UPD;
        end else begin
          dig_d   = dig_q + 1'b1;
          state_d = swlfg_pkg::ST_DIV_MUL;
        end
      end
      swlfg_pkg::ST_PH_UPD: begin
        cmd_o.op = swlfg_pkg::OP_PH_UPD;
        state_d  = swlfg_pkg::ST_PROD;
      end
      swlfg_pkg::ST_PROD: begin
        cmd_o.op = swlfg_pkg::OP_PROD;
        state_d  = swlfg_pkg::ST_PROD_SUM;
      end
      swlfg_pkg::ST_PROD_SUM: begin
        cmd_o.op = swlfg_pkg::OP_PROD_SUM;
        state_d  = swlfg_pkg::ST_MOT_MUL;
      end
      swlfg_pkg::ST_MOT_MUL: begin
        cmd_o.op = swlfg_pkg::OP_MOT_MUL;
        state_d  = swlfg_pkg::ST_MOT_SUM;
      end
      swlfg_pkg::ST_MOT_SUM: begin
        cmd_o.op = swlfg_pkg::OP_MOT_SUM;
        led_d    = '0;
        state_d  = swlfg_pkg::ST_PIXEL;
      end
      swlfg_pkg::ST_PIXEL: begin
        cmd_o.op = swlfg_pkg::OP_PIXEL;
        // advance only when the pixel pipeline takes the issue
        if (status_i.pipe_adv) begin
          if (led_q == swlfg_pkg::LED_IDX_W'(swlfg_pkg::LED_COUNT - 1)) begin
            state_d = swlfg_pkg::ST_IDLE;
          end else begin
            led_d = led_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = swlfg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/swlfg_datapath.sv @@
// Datapath for the frame generator: configuration registers, phase and
// motion arithmetic, and the four-stage pixel pipeline. Depends on swlfg_pkg.
`default_nettype none

module swlfg_datapath (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [swlfg_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [swlfg_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  wire logic                                  command_i,
  input  wire logic [23:0]                           elapsed_ms_i,
  input  wire logic [16:0]                           scrub_time_i,
  input  wire swlfg_pkg::dp_cmd_t                    cmd_i,
  output swlfg_pkg::dp_status_t                      status_o,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic [swlfg_pkg::LED_INDEX_W-1:0]          led_index_o,
  output logic [7:0]                                 red_o,
  output logic [7:0]                                 green_o,
  output logic [7:0]                                 blue_o,
  output logic                                       last_o
);

  // Configuration and state
  logic signed [15:0]                    speed_q;
  logic [15:0]                           intensity_q;
  logic [swlfg_pkg::PHASE_W-1:0]         phase_q;

  // Captured transaction and division by 1000
  logic                                  cmd_q;
  logic [16:0]                           scrub_q;
  logic [39:0]                           num_q;
  logic [17:0]                           n_q;
  logic [7:0]                            qdig_q;
  logic [9:0]                            rem_q;
  logic [31:0]                           quot_q;

  // Motion term
  logic signed [35:0]                    plo_q, phi_q;
  logic [53:0]                           p_q;
  logic [31:0]                           hk_q;
  logic [25:0]                           lk_q;
  logic [31:0]                           motion_q;

  // Pixel pipeline
  logic                                  adv;
  logic                                  issue;
  logic                                  vld1_q, vld2_q, vld3_q, out_valid_q;
  logic [31:0]                           turns_q;
  logic [15:0]                           sine_q;
  logic                                  neg_q;
  logic [7:0]                            v_q;
  logic [swlfg_pkg::LED_IDX_W-1:0]       led1_q, led2_q, led3_q, led_out_q;
  logic                                  last_q;
  logic [7:0]                            red_q, green_q, blue_q;

  // Combinational terms
  logic [17:0]                           n_d;
  logic [36:0]                           dprod;
  logic [swlfg_pkg::PHASE_W-1:0]         sum;
  logic [31:0]                           hi32;
  logic [57:0]                           hprod;
  logic [57:0]                           lprod;
  logic [swlfg_pkg::SINE_TABLE_BITS-1:0] tidx;
  logic [1:0]                            quad;
  logic [swlfg_pkg::QTAB_IDX_W-1:0]      xpos;
  logic [swlfg_pkg::QTAB_IDX_W-1:0]      qpos;
  logic [16:0]                           wave;
  logic [32:0]                           vprod;

  assign adv        = !out_valid_q || out_ready_i;
  assign issue      = (cmd_i.op == swlfg_pkg::OP_PIXEL) && adv;
  assign status_o.pipe_adv = adv;

  assign n_d   = {rem_q, num_q[39:32]};
  assign dprod = 37'(n_d) * 37'(swlfg_pkg::DIV_M);
  assign sum   = phase_q + swlfg_pkg::PHASE_W'(quot_q);
  assign hi32  = {{10{p_q[53]}}, p_q[53:32]};
  assign hprod = 58'(hi32) * 58'(swlfg_pkg::KMOT);
  assign lprod = 58'(p_q[31:0]) * 58'(swlfg_pkg::KMOT);

  // Fold the table index into one quadrant; odd quadrants run mirrored
  assign tidx = turns_q[31 -: swlfg_pkg::SINE_TABLE_BITS];
  assign quad = tidx[swlfg_pkg::SINE_TABLE_BITS-1 -: 2];
  assign xpos = {1'b0, tidx[swlfg_pkg::QBITS-1:0]};
  assign qpos = quad[0] ? (swlfg_pkg::QTAB_IDX_W'(1 << swlfg_pkg::QBITS) - xpos) : xpos;
  assign wave  = neg_q ? (17'd32768 - 17'(sine_q)) : (17'd32768 + 17'(sine_q));
  assign vprod = 33'(wave) * 33'(intensity_q);

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q     <= signed'(swlfg_pkg::SPEED_RST);
      intensity_q <= swlfg_pkg::INTENSITY_RST;
      phase_q     <= '0;
      vld1_q      <= 1'b0;
      vld2_q      <= 1'b0;
      vld3_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (swlfg_pkg::cfg_reg_e'(cfg_index_i))
          swlfg_pkg::REG_SPEED:     speed_q     <= signed'(cfg_wdata_i);
          swlfg_pkg::REG_INTENSITY: intensity_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.op == swlfg_pkg::OP_PH_UPD) begin
        if (cmd_q) begin
          phase_q <= swlfg_pkg::PHASE_W'(38'(scrub_q) * swlfg_pkg::SCRUB_SCALE);
        end else if (sum > swlfg_pkg::PHASE_LIMIT) begin
          phase_q <= '0;
        end else begin
          phase_q <= sum;
        end
      end
      if (adv) begin
        vld1_q      <= issue;
        vld2_q      <= vld1_q;
        vld3_q      <= vld2_q;
        out_valid_q <= vld3_q;
      end
    end
  end

  // Arithmetic sequence, one step per command
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      swlfg_pkg::OP_LOAD: begin
        cmd_q   <= command_i;
        scrub_q <= scrub_time_i;
        num_q   <= {elapsed_ms_i, 16'd0};
        rem_q   <= '0;
        quot_q  <= '0;
      end
      swlfg_pkg::OP_DIV_MUL: begin
        n_q    <= n_d;
        qdig_q <= dprod[35:28];
        num_q  <= num_q << 8;
      end
      swlfg_pkg::OP_DIV_REM: begin
        rem_q  <= 10'(n_q - 18'(qdig_q) * swlfg_pkg::DIV_D);
        quot_q <= {quot_q[23:0], qdig_q};
      end
      swlfg_pkg::OP_PROD: begin
        plo_q <= $signed({1'b0, phase_q[18:0]}) * speed_q;
        phi_q <= $signed({1'b0, phase_q[37:19]}) * speed_q;
      end
      swlfg_pkg::OP_PROD_SUM: begin
        p_q <= ({{18{phi_q[35]}}, phi_q} << 19) + {{18{plo_q[35]}}, plo_q};
      end
      swlfg_pkg::OP_MOT_MUL: begin
        hk_q <= hprod[31:0];
        lk_q <= lprod[57:32];
      end
      swlfg_pkg::OP_MOT_SUM: begin
        motion_q <= hk_q + 32'(lk_q);
      end
      default: ;
    endcase
  end

  // Pixel pipeline payload: angle, quarter-wave lookup, scale, colour
  always_ff @(posedge clk_i) begin
    if (adv) begin
      turns_q   <= swlfg_pkg::LED_TURN[cmd_i.led] + motion_q;
      led1_q    <= cmd_i.led;
      sine_q    <= swlfg_pkg::QTAB[qpos];
      neg_q     <= quad[1];
      led2_q    <= led1_q;
      v_q       <= vprod[31:24];
      led3_q    <= led2_q;
      red_q     <= v_q;
      green_q   <= swlfg_pkg::GREEN_LUT[v_q];
      blue_q    <= 8'd255 - v_q;
      led_out_q <= led3_q;
      last_q    <= (led3_q == swlfg_pkg::LED_IDX_W'(swlfg_pkg::LED_COUNT - 1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign led_index_o = swlfg_pkg::LED_INDEX_W'(led_out_q);
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

@@ sv/sine_wave_led_frame_generator.sv @@
// Sine-wave LED frame generator: one transaction in, LED_COUNT pixels out.
// A transaction is accepted in idle, then runs the byte-digit division by 1000,
// the phase update and motion products, then issues one pixel per cycle while
// the output is not stalled; a new transaction is taken only after the last issue.
// Pixels leave through a 4-stage pipeline.
// Reset: asynchronous, active low; phase clears, speed and intensity reload.
`default_nettype none

module sine_wave_led_frame_generator (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [swlfg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [swlfg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             command_i,
  input  wire logic [23:0]                      elapsed_ms_i,
  input  wire logic [16:0]                      scrub_time_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [swlfg_pkg::LED_INDEX_W-1:0]     led_index_o,
  output logic [7:0]                            red_o,
  output logic [7:0]                            green_o,
  output logic [7:0]                            blue_o,
  output logic                                  last_o
);

  swlfg_pkg::dp_cmd_t    cmd;
  swlfg_pkg::dp_status_t status;

  swlfg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  swlfg_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .command_i    (command_i),
    .elapsed_ms_i (elapsed_ms_i),
    .scrub_time_i (scrub_time_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .led_index_o  (led_index_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

@@ sv/swlfg_checker.sv @@
// Port-level checks for the frame generator, bound to the top level.
// Depends on swlfg_pkg and sine_wave_led_frame_generator.
`default_nettype none

module swlfg_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             cfg_we_i,
  input wire logic [swlfg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input wire logic [swlfg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input wire logic                             in_valid_i,
  input wire logic                             in_ready_o,
  input wire logic                             command_i,
  input wire logic [23:0]                      elapsed_ms_i,
  input wire logic [16:0]                      scrub_time_i,
  input wire logic                             out_valid_o,
  input wire logic                             out_ready_i,
  input wire logic [swlfg_pkg::LED_INDEX_W-1:0] led_index_o,
  input wire logic [7:0]                       red_o,
  input wire logic [7:0]                       green_o,
  input wire logic [7:0]                       blue_o,
  input wire logic                             last_o
);

  // hold a stalled pixel
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_o) && $stable(led_index_o))
    else $error("stalled pixel changed");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> led_index_o == swlfg_pkg::LED_INDEX_W'(swlfg_pkg::LED_COUNT - 1))
    else $error("last flag on wrong LED");

  a_next_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=>
      !out_valid_o || led_index_o == swlfg_pkg::LED_INDEX_W'($past(led_index_o) + 1'b1))
    else $error("LED order broken within frame");

  a_blue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> blue_o == 8'(8'd255 - red_o))
    else $error("blue is not the complement of red");

  a_green: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> green_o <= red_o)
    else $error("green exceeds red");

endmodule

bind sine_wave_led_frame_generator swlfg_checker u_swlfg_checker (.*);

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for sine_wave_led_frame_generator: queued frame
// requests go in, every pixel is predicted in fixed point and checked in order.
// Depends on swlfg_pkg and the block's RTL; reads nothing else.

module testbench;

  localparam int unsigned N_LEDS      = 64;
  localparam int unsigned TAB_BITS    = 10;
  localparam int unsigned QUAD_BITS   = TAB_BITS - 2;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 800;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned WRAP_FRAMES = 156;

  localparam logic CMD_ADVANCE = 1'b0;
  localparam logic CMD_SCRUB   = 1'b1;

  localparam logic [15:0] SPEED_AT_RESET     = 16'd5120;
  localparam logic [15:0] INTENSITY_AT_RESET = 16'd43520;
  localparam logic [37:0] PHASE_CEIL         = 38'd167772160000;  // 10000 s in Q14.24
  localparam logic [63:0] LED_SPAN_TURNS     = 64'd16405566614;   // 24 rad in Q0.32 turns
  localparam logic [63:0] MOTION_K           = 64'd34178264;      // 0.05 rad in Q0.32 turns
  localparam logic [63:0] SIN_C1 = 64'd1686629713;
  localparam logic [63:0] SIN_C3 = 64'd693598668;
  localparam logic [63:0] SIN_C5 = 64'd85569306;
  localparam logic [63:0] SIN_C7 = 64'd5026995;
  localparam logic [63:0] SIN_C9 = 64'd172272;

  typedef enum int unsigned {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic       command;
    logic [23:0] elapsed;
    logic [16:0] scrub;
    idle_mode_e  mode;
  } frame_req_t;

  typedef struct packed {
    logic [5:0] led;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       is_last;
  } pixel_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                                cfg_we    = 1'b0;
  logic [swlfg_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [swlfg_pkg::CFG_DATA_W-1:0]    cfg_wdata = '0;
  logic                                in_valid   = 1'b0;
  logic                                command    = 1'b0;
  logic [23:0]                         elapsed_ms = '0;
  logic [16:0]                         scrub_time = '0;
  logic                                out_ready  = 1'b0;

  logic                                dut_ready;
  logic                                pix_valid;
  logic [swlfg_pkg::LED_INDEX_W-1:0]   pix_led;
  logic [7:0]                          pix_red;
  logic [7:0]                          pix_green;
  logic [7:0]                          pix_blue;
  logic                                pix_last;

  frame_req_t  pending_frames[$];
  pixel_t      expected_pixels[$];
  idle_mode_e  traffic_mode = IDLE_NONE;
  logic        in_fire_q    = 1'b0;
  logic        rx_hold      = 1'b0;
  logic        squeeze_go   = 1'b0;

  // Predicted block state
  logic [37:0] phase_s     = '0;
  logic [15:0] speed_r     = SPEED_AT_RESET;
  logic [15:0] intensity_r = INTENSITY_AT_RESET;

  int unsigned mismatches     = 0;
  int unsigned frames_done    = 0;
  int unsigned pixels_checked = 0;
  int unsigned scrubs_done    = 0;
  int unsigned ceiling_clears = 0;
  int unsigned cycles         = 0;

  sine_wave_led_frame_generator u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (dut_ready),
    .command_i    (command),
    .elapsed_ms_i (elapsed_ms),
    .scrub_time_i (scrub_time),
    .out_valid_o  (pix_valid),
    .out_ready_i  (out_ready),
    .led_index_o  (pix_led),
    .red_o        (pix_red),
    .green_o      (pix_green),
    .blue_o       (pix_blue),
    .last_o       (pix_last)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned send_gap_pct(idle_mode_e m);
    case (m)
      IDLE_SEND: return 86;
      IDLE_BOTH: return 18;
      default:   return 0;
    endcase
  endfunction

  function automatic int unsigned recv_stall_pct(idle_mode_e m);
    case (m)
      IDLE_RECV: return 86;
      IDLE_BOTH: return 18;
      default:   return 0;
    endcase
  endfunction

  // 0.5 + 0.5*sin for one table index, Q16
  function automatic logic [16:0] wave_q16(logic [TAB_BITS-1:0] idx);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] t;
    logic [63:0] s;
    z = 64'(idx[QUAD_BITS-1:0]) << (16 - QUAD_BITS);
    if (idx[QUAD_BITS]) begin
      z = 64'd65536 - z;
    end
    z2 = (z * z) >> 16;
    t  = SIN_C9;
    t  = SIN_C7 - ((t * z2) >> 16);
    t  = SIN_C5 - ((t * z2) >> 16);
    t  = SIN_C3 - ((t * z2) >> 16);
    t  = SIN_C1 - ((t * z2) >> 16);
    s  = ((t * z) >> 16) >> 15;
    if (s > 64'd32768) begin
      s = 64'd32768;
    end
    return idx[QUAD_BITS+1] ? 17'(64'd32768 - s) : 17'(64'd32768 + s);
  endfunction

  // Update the phase for one request and queue the pixels of its frame
  task automatic predict_frame(logic cmd, logic [23:0] el, logic [16:0] sc);
    logic [63:0] acc;
    logic [63:0] spd;
    logic [63:0] prod;
    logic [63:0] mot;
    logic [63:0] lamp;
    logic [63:0] lvl;
    logic [31:0] turns;
    logic [7:0]  v;
    pixel_t      px;
    if (cmd == CMD_ADVANCE) begin
      acc     = 64'(phase_s) + ((64'(el) << 16) / 64'd1000);
      phase_s = acc[37:0];
      if (phase_s > PHASE_CEIL) begin
        phase_s = '0;
        ceiling_clears++;
      end
    end else begin
      acc     = (64'(sc) * 64'd10) << 8;
      phase_s = acc[37:0];
      scrubs_done++;
    end
    spd  = {{48{speed_r[15]}}, speed_r};
    prod = 64'(phase_s) * spd;
    mot  = ({32'd0, prod[63:32]} * MOTION_K) + (({32'd0, prod[31:0]} * MOTION_K) >> 32);
    for (int i = 0; i < N_LEDS; i++) begin
      lamp       = (64'(i) * LED_SPAN_TURNS) / 64'(N_LEDS - 1);
      turns      = lamp[31:0] + mot[31:0];
      lvl        = 64'(wave_q16(turns[31 -: TAB_BITS])) * 64'(intensity_r);
      v          = lvl[31:24];
      px.led     = 6'(i);
      px.red     = v;
      px.green   = 8'((16'(v) * 16'd62) / 16'd100);
      px.blue    = 8'd255 - v;
      px.is_last = (i == N_LEDS - 1);
      expected_pixels.push_back(px);
    end
  endtask

  function automatic void check_field(string name, int unsigned led,
                                      logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: pixel %0d %s expected %0d, got %0d", $time, led, name, want, got);
      mismatches++;
    end
  endfunction

  // Hand requests to the block; hold each one until it is taken
  always @(negedge clk_i) begin : drive_frames
    frame_req_t req;
    if (rst_ni && (!in_valid || in_fire_q)) begin
      if (pending_frames.size() != 0 &&
          $urandom_range(99) >= send_gap_pct(pending_frames[0].mode)) begin
        req = pending_frames.pop_front();
        in_valid     <= 1'b1;
        command      <= req.command;
        elapsed_ms   <= req.elapsed;
        scrub_time   <= req.scrub;
        traffic_mode <= req.mode;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready <= rst_ni && !rx_hold && ($urandom_range(99) >= recv_stall_pct(traffic_mode));
  end

  // Long receiver hold-off so that the block backs up into its input
  initial begin
    wait (squeeze_go);
    @(negedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin : check_pixels
    pixel_t want;
    if (!rst_ni) begin
      in_fire_q <= 1'b0;
    end else begin
      in_fire_q <= in_valid && dut_ready;
      if (cfg_we) begin
        case (swlfg_pkg::cfg_reg_e'(cfg_index))
          swlfg_pkg::REG_SPEED:     speed_r     = cfg_wdata;
          swlfg_pkg::REG_INTENSITY: intensity_r = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && dut_ready) begin
        predict_frame(command, elapsed_ms, scrub_time);
        frames_done++;
      end
      if (pix_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: pixel with none expected, got led %0d", $time, pix_led);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("led_index", want.led, 8'(want.led), 8'(pix_led));
          check_field("red", want.led, want.red, pix_red);
          check_field("green", want.led, want.green, pix_green);
          check_field("blue", want.led, want.blue, pix_blue);
          check_field("last", want.led, 8'(want.is_last), 8'(pix_last));
          pixels_checked++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timed out after %0d cycles, %0d pixels outstanding",
               $time, cycles, expected_pixels.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic add_frame(logic cmd, logic [23:0] el, logic [16:0] sc, idle_mode_e mode);
    frame_req_t req;
    req.command = cmd;
    req.elapsed = el;
    req.scrub   = sc;
    req.mode    = mode;
    pending_frames.push_back(req);
  endtask

  task automatic add_random(int unsigned n, idle_mode_e mode);
    logic [23:0] el;
    logic [16:0] sc;
    repeat (n) begin
      el = ($urandom_range(4) == 0) ? 24'($urandom_range(2000)) : 24'($urandom());
      sc = ($urandom_range(4) == 0) ? 17'(65532 + $urandom_range(8))
                                    : 17'($urandom_range(131071));
      add_frame(1'($urandom_range(1)), el, sc, mode);
    end
  endtask

  // Drain the block completely, then leave room for its pipeline to empty
  task automatic wait_idle();
    while (pending_frames.size() != 0 || in_valid || expected_pixels.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic program_regs(logic [15:0] spd, logic [15:0] inten);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= swlfg_pkg::REG_SPEED;
    cfg_wdata <= spd;
    @(negedge clk_i);
    cfg_index <= swlfg_pkg::REG_INTENSITY;
    cfg_wdata <= inten;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [23:0] el;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: field extremes, both commands, ignored fields
    add_frame(CMD_ADVANCE, 24'd0, 17'd0, IDLE_NONE);
    add_frame(CMD_ADVANCE, 24'd1, 17'd0, IDLE_NONE);
    add_frame(CMD_ADVANCE, 24'hFFFFFF, 17'd0, IDLE_NONE);
    add_frame(CMD_ADVANCE, 24'hAAAAAA, 17'h15555, IDLE_NONE);
    add_frame(CMD_ADVANCE, 24'h555555, 17'h0AAAA, IDLE_NONE);
    add_frame(CMD_SCRUB, 24'd0, 17'd0, IDLE_NONE);
    add_frame(CMD_SCRUB, 24'hFFFFFF, 17'd65536, IDLE_NONE);
    add_frame(CMD_SCRUB, 24'd0, 17'h1FFFF, IDLE_NONE);      // beyond one, no clamp
    add_frame(CMD_SCRUB, 24'd0, 17'd32768, IDLE_NONE);
    add_frame(CMD_SCRUB, 24'h123456, 17'h15555, IDLE_NONE);
    add_frame(CMD_SCRUB, 24'd0, 17'h0AAAA, IDLE_NONE);
    add_frame(CMD_ADVANCE, 24'd1000, 17'd0, IDLE_NONE);

    // Fastest forward speed, full brightness
    wait_idle();
    program_regs(16'h7FFF, 16'hFFFF);
    add_frame(CMD_SCRUB, 24'd0, 17'h1FFFF, IDLE_SEND);
    add_frame(CMD_ADVANCE, 24'hFFFFFF, 17'd0, IDLE_SEND);
    add_random(3, IDLE_SEND);

    // Most negative speed, dark
    wait_idle();
    program_regs(16'h8000, 16'h0000);
    add_frame(CMD_SCRUB, 24'd0, 17'd65536, IDLE_RECV);
    add_random(3, IDLE_RECV);

    // Small reverse speed, unit brightness
    wait_idle();
    program_regs(16'hFFFF, 16'h0100);
    add_frame(CMD_SCRUB, 24'd0, 17'h1FFFF, IDLE_BOTH);
    add_random(3, IDLE_BOTH);

    // Still wave while the receiver holds off
    wait_idle();
    program_regs(16'h0000, 16'($urandom()));
    squeeze_go = 1'b1;
    add_random(5, IDLE_NONE);

    // Long run of near-full advances, enough to carry the phase past its ceiling
    wait_idle();
    program_regs(16'($urandom()), 16'($urandom()));
    for (int k = 0; k < WRAP_FRAMES; k++) begin
      el = 24'($urandom_range(24'hFFFFFF, 24'hFF0000));
      add_frame(CMD_ADVANCE, el, 17'($urandom()), idle_mode_e'((k / 39) % 4));
    end

    wait_idle();
    $display("Rendered %0d frames (%0d scrubs) and compared %0d pixels;",
             frames_done, scrubs_done, pixels_checked);
    $display("phase cleared at its ceiling %0d times, %0d mismatches.",
             ceiling_clears, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sine_wave_led_frame_generator.f @@
sv/swlfg_pkg.sv
sv/swlfg_ctrl.sv
sv/swlfg_datapath.sv
sv/sine_wave_led_frame_generator.sv
sv/swlfg_checker.sv
dv/testbench.sv
